// ===== hdl/windowed_latency_stats_monitor_defines.svh =====
// Assertion macros used by the windowed latency stats monitor back end.
`ifndef WINDOWED_LATENCY_STATS_MONITOR_DEFINES_SVH
`define WINDOWED_LATENCY_STATS_MONITOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WLSM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define WLSM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/wlsm_pkg.sv =====
// Package: widths, constants, types and helpers of the latency stats monitor.
package wlsm_pkg;

    localparam int PROBE_W        = 6;
    localparam int DUR_W          = 64;
    localparam int TIME_W         = 63;
    localparam int CNT_W          = 32;
    localparam int CFG_W          = 32;
    localparam int DEF_NUM_PROBES = 64;
    localparam int QUEUE_DEPTH    = 4;

    localparam logic [CFG_W-1:0] CFG_RESET   = 32'd10000;
    localparam logic [DUR_W-1:0] LOW_THRESH  = 64'd250000;
    localparam logic [DUR_W-1:0] HIGH_THRESH = 64'd1000000;

    // Classified sample, front to back.
    typedef struct packed {
        logic [PROBE_W-1:0] probe;
        logic               probe_ok;
        logic [DUR_W-1:0]   dur;
        logic               over_low;
        logic               over_high;
        logic               report;
        logic [TIME_W-1:0]  elapsed;
    } t_cmd;

    // Queue status seen by both sides.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_flags;

    // One statistics table entry.
    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        logic [DUR_W-1:0] total;
        logic [DUR_W-1:0] max;
        logic [CNT_W-1:0] low;
        logic [CNT_W-1:0] high;
    } t_stats;

    typedef enum logic [1:0] {
        S_IDLE,
        S_UPD,
        S_RPT_RD,
        S_RPT_OUT
    } t_bk_state;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v == '1) ? v : v + CNT_W'(1);
    endfunction

endpackage

// ===== hdl/wlsm_queue.sv =====
// Small command FIFO between the classify front and the table back end.
module wlsm_queue
    import wlsm_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_cmd     i_cmd,
    input  logic     i_pop,
    output t_cmd     o_head,
    output t_q_flags o_flags
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_QW = PTR_W + 1;

    t_cmd              r_buf [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_QW-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_flags.full  = (r_count == CNT_QW'(DEPTH));
    assign o_flags.empty = (r_count == '0);
    assign do_push = i_push && !o_flags.full;
    assign do_pop  = i_pop && !o_flags.empty;
    assign o_head  = r_buf[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            unique case ({do_push, do_pop})
                2'b10:   r_count <= r_count + CNT_QW'(1);
                2'b01:   r_count <= r_count - CNT_QW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_buf[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// ===== hdl/wlsm_front.sv =====
// Front end: takes samples, tracks the time window, classifies each sample.
module wlsm_front
    import wlsm_pkg::*;
#(
    parameter int NUM_PROBES = DEF_NUM_PROBES
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [CFG_W-1:0]   i_cfg_wr_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [PROBE_W-1:0] i_probe_index,
    input  logic [DUR_W-1:0]   i_duration_ns,
    input  logic [TIME_W-1:0]  i_time_ms,
    input  t_q_flags           i_q_flags,
    output logic               o_push,
    output t_cmd               o_cmd
);

    logic [CFG_W-1:0]  r_interval;
    logic [TIME_W-1:0] r_win_start;
    logic              r_win_open;

    logic [TIME_W-1:0] start_eff;
    logic [TIME_W:0]   deadline;
    logic              reached;

    assign o_in_ready = !i_q_flags.full;
    assign o_push     = i_in_valid && o_in_ready;

    // First sample opens the window at its own time.
    assign start_eff = r_win_open ? r_win_start : i_time_ms;
    assign deadline  = {1'b0, start_eff} + (TIME_W + 1)'(r_interval);
    assign reached   = ({1'b0, i_time_ms} >= deadline);

    always_comb begin
        o_cmd.probe     = i_probe_index;
        o_cmd.probe_ok  = ((PROBE_W + 1)'(i_probe_index) < (PROBE_W + 1)'(NUM_PROBES));
        o_cmd.dur       = i_duration_ns;
        o_cmd.over_low  = (i_duration_ns >= LOW_THRESH);
        o_cmd.over_high = (i_duration_ns >= HIGH_THRESH);
        o_cmd.report    = reached;
        o_cmd.elapsed   = i_time_ms - start_eff;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval  <= CFG_RESET;
            r_win_open  <= 1'b0;
            r_win_start <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_interval <= i_cfg_wr_data;
            end
            if (o_push) begin
                r_win_open <= 1'b1;
                if (!r_win_open || reached) begin
                    r_win_start <= i_time_ms;
                end
            end
        end
    end

endmodule

// ===== hdl/wlsm_back.sv =====
// Back end: statistics table update and report walk with output register.
module wlsm_back
    import wlsm_pkg::*;
#(
    parameter int NUM_PROBES = DEF_NUM_PROBES
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_q_flags           i_q_flags,
    input  t_cmd               i_head,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [PROBE_W-1:0] o_entry_index,
    output logic [CNT_W-1:0]   o_sample_count,
    output logic [DUR_W-1:0]   o_total_time_ns,
    output logic [DUR_W-1:0]   o_max_time_ns,
    output logic [CNT_W-1:0]   o_count_over_low,
    output logic [CNT_W-1:0]   o_count_over_high,
    output logic [TIME_W-1:0]  o_window_length_ms,
    output logic               o_last_entry
);

`include "windowed_latency_stats_monitor_defines.svh"

    localparam int ADDR_W = (NUM_PROBES > 1) ? $clog2(NUM_PROBES) : 1;

    t_bk_state r_state;
    t_bk_state n_state;

    t_cmd                  r_cmd;
    logic [ADDR_W-1:0]     r_k;
    logic [NUM_PROBES-1:0] r_valid;
    t_stats                r_mem [NUM_PROBES];
    t_stats                r_rd_data;
    logic                  r_rd_vld;
    logic                  r_out_valid;

    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              load;
    logic              last_k;
    logic              clr;
    t_stats            cur;
    t_stats            upd;

    // Entries not written since the last clear read as zero.
    assign cur     = r_rd_vld ? r_rd_data : '0;
    assign last_k  = (r_k == ADDR_W'(NUM_PROBES - 1));
    assign wr_addr = r_cmd.probe[ADDR_W-1:0];
    assign clr     = load && last_k;

    always_comb begin
        upd.cnt   = sat_inc(cur.cnt);
        upd.total = cur.total + r_cmd.dur;
        upd.max   = (r_cmd.dur > cur.max) ? r_cmd.dur : cur.max;
        upd.low   = r_cmd.over_low ? sat_inc(cur.low) : cur.low;
        upd.high  = r_cmd.over_high ? sat_inc(cur.high) : cur.high;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (!i_q_flags.empty) begin
                    if (i_head.probe_ok) begin
                        n_state = S_UPD;
                    end else if (i_head.report) begin
                        n_state = S_RPT_RD;
                    end
                end
            end
            S_UPD:     n_state = r_cmd.report ? S_RPT_RD : S_IDLE;
            S_RPT_RD:  n_state = S_RPT_OUT;
            S_RPT_OUT: begin
                if (load) begin
                    n_state = last_k ? S_IDLE : S_RPT_RD;
                end
            end
            default:   n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        o_pop   = 1'b0;
        rd_en   = 1'b0;
        rd_addr = r_k;
        wr_en   = 1'b0;
        load    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_pop   = !i_q_flags.empty;
                rd_en   = !i_q_flags.empty;
                rd_addr = i_head.probe[ADDR_W-1:0];
            end
            S_UPD:     wr_en = 1'b1;
            S_RPT_RD:  rd_en = 1'b1;
            S_RPT_OUT: load  = !r_out_valid || i_out_ready;
            default: begin
                o_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_k         <= '0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_pop) begin
                r_k <= '0;
            end else if (load) begin
                r_k <= r_k + ADDR_W'(1);
            end
            if (clr) begin
                r_valid <= '0;
            end else if (wr_en) begin
                r_valid[wr_addr] <= 1'b1;
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_head;
        end
    end

    // Table memory, one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= upd;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
            r_rd_vld  <= r_valid[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            o_entry_index      <= PROBE_W'(r_k);
            o_sample_count     <= cur.cnt;
            o_total_time_ns    <= cur.total;
            o_max_time_ns      <= cur.max;
            o_count_over_low   <= cur.low;
            o_count_over_high  <= cur.high;
            o_window_length_ms <= r_cmd.elapsed;
            o_last_entry       <= last_k;
        end
    end

    assign o_out_valid = r_out_valid;

    `WLSM_ASSERT_NOW(a_upd_in_range, i_clk, i_rst_n, r_state == S_UPD, r_cmd.probe_ok, "update of out-of-range probe")
    `WLSM_ASSERT_NOW(a_walk_needs_report, i_clk, i_rst_n, (r_state == S_RPT_RD) || (r_state == S_RPT_OUT), r_cmd.report, "report walk without report")
    `WLSM_ASSERT_NEXT(a_clear_after_walk, i_clk, i_rst_n, clr, r_valid == '0, "table not cleared after report")
    `WLSM_ASSERT_NOW(a_last_index, i_clk, i_rst_n, o_out_valid && o_last_entry, o_entry_index == PROBE_W'(NUM_PROBES - 1), "last flag on wrong entry")

endmodule

// ===== hdl/windowed_latency_stats_monitor.sv =====
// Top level of the windowed latency statistics monitor.
//
// Each sample transfer carries a probe index, a measured duration in ns and the
// current time in ms. The first sample after reset opens the time window; every
// sample updates its probe's table entry (saturating sample count, wrapping
// 64-bit total, maximum, saturating counts at/above 250 us and 1 ms; an index
// at or above NUM_PROBES updates nothing). When elapsed time (time_ms minus
// window start) reaches the configured report interval, all NUM_PROBES entries
// go out in index order, the last one flagged, then the table clears and the
// window restarts at that sample's time. A time below the window start never
// reports.
// The front end classifies samples in the cycle they arrive and pushes them
// into a 4-entry queue; the back end sequencer drains it. Each in-range sample
// takes a registered table read, then a write back; an out-of-range sample
// without report is only popped. A report reads each entry, then loads it into
// the output register, and waits on any output stall.
// Samples keep being accepted while the queue has room, including during a
// report. Table clearing is done by per-entry valid flags, so neither reset nor
// a report needs a clearing pass. The interval register may be written any time
// the block is idle; it takes effect for the next sample.
module windowed_latency_stats_monitor
    import wlsm_pkg::*;
#(
    parameter int NUM_PROBES = DEF_NUM_PROBES
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Configuration: report interval in ms
    input  logic               i_cfg_wr_en,
    input  logic [CFG_W-1:0]   i_cfg_wr_data,
    // Sample input
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [PROBE_W-1:0] i_probe_index,
    input  logic [DUR_W-1:0]   i_duration_ns,
    input  logic [TIME_W-1:0]  i_time_ms,
    // Report output
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [PROBE_W-1:0] o_entry_index,
    output logic [CNT_W-1:0]   o_sample_count,
    output logic [DUR_W-1:0]   o_total_time_ns,
    output logic [DUR_W-1:0]   o_max_time_ns,
    output logic [CNT_W-1:0]   o_count_over_low,
    output logic [CNT_W-1:0]   o_count_over_high,
    output logic [TIME_W-1:0]  o_window_length_ms,
    output logic               o_last_entry
);

    t_cmd     push_cmd;
    t_cmd     head_cmd;
    t_q_flags q_flags;
    logic     push;
    logic     pop;

    // Window tracking, interval register and per-sample classification.
    wlsm_front #(
        .NUM_PROBES (NUM_PROBES)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_probe_index (i_probe_index),
        .i_duration_ns (i_duration_ns),
        .i_time_ms     (i_time_ms),
        .i_q_flags     (q_flags),
        .o_push        (push),
        .o_cmd         (push_cmd)
    );

    // Decouples sample intake from table work and report stalls.
    wlsm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_head  (head_cmd),
        .o_flags (q_flags)
    );

    // Table read-modify-write and report walk.
    wlsm_back #(
        .NUM_PROBES (NUM_PROBES)
    ) u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_q_flags          (q_flags),
        .i_head             (head_cmd),
        .o_pop              (pop),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_entry_index      (o_entry_index),
        .o_sample_count     (o_sample_count),
        .o_total_time_ns    (o_total_time_ns),
        .o_max_time_ns      (o_max_time_ns),
        .o_count_over_low   (o_count_over_low),
        .o_count_over_high  (o_count_over_high),
        .o_window_length_ms (o_window_length_ms),
        .o_last_entry       (o_last_entry)
    );

endmodule
